### src/two_beam_object_length_meter_top_assert.svh
// ---------------------------------------------------------------------------
// two-beam object length meter: assertion macros
// shared forms of the concurrent checks used in the rtl
// ---------------------------------------------------------------------------
`ifndef TWO_BEAM_OBJECT_LENGTH_METER_TOP_ASSERT_SVH
`define TWO_BEAM_OBJECT_LENGTH_METER_TOP_ASSERT_SVH

// condition holds on every clock edge out of reset
`define TBOLM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("tbolm: invariant violated");

// consequent holds in the cycle of the antecedent
`define TBOLM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbolm: implication violated");

`endif

### src/tbolm_pkg.sv
// ---------------------------------------------------------------------------
// tbolm_pkg
// types, constants and helpers shared by the length meter modules
// ---------------------------------------------------------------------------
package tbolm_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int TIME_BITS   = 32;
   localparam int EDGE_W      = 32;
   localparam int DIST_W      = 20;
   localparam int LEN_W       = 32;

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W  = FILL_W + 1;
   localparam int REM_W  = TIME_BITS + 1;
   localparam int PROD_W = REM_W + DIST_W;
   localparam int CNT_W  = $clog2(PROD_W);

   localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
   localparam logic [FILL_W-1:0] FILL_TWO  = FILL_W'(2);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(PROD_W - 1);
   localparam logic [DIST_W-1:0] DIST_RESET = DIST_W'(100000);

   typedef enum logic {
      CMD_RECORD = 1'b0,
      CMD_CLEAR  = 1'b1
   } command_type;

   typedef enum logic {
      SENSOR_A = 1'b0,
      SENSOR_B = 1'b1
   } sensor_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ZERO_DELAY = 2'd1,
      STATUS_SATURATED  = 2'd2,
      STATUS_DROPPED    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      EMIT_DROP = 2'd0,
      EMIT_ZERO = 2'd1,
      EMIT_CALC = 2'd2
   } emit_type;

   typedef struct packed {
      command_type       command;
      sensor_type        sensor_select;
      logic [EDGE_W-1:0] edge_time;
   } req_payload_type;

   typedef struct packed {
      status_type       status;
      logic [LEN_W-1:0] object_length;
   } rsp_payload_type;

   typedef struct packed {
      logic     clear;
      logic     push;
      logic     rd_next;
      logic     cap_in;
      logic     pop;
      logic     calc_diff;
      logic     calc_sum;
      logic     mul;
      logic     div_step;
      logic     load;
      emit_type emit_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic item_clear;
      logic item_full;
      logic pair_ready;
      logic den_zero;
      logic div_last;
      logic out_free;
   } dp_status_type;

   function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0]  base,
                                                input logic [FILL_W-1:0] step);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(step);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [TIME_BITS-1:0] abs_diff(input logic [TIME_BITS-1:0] x,
                                                     input logic [TIME_BITS-1:0] y);
      logic [TIME_BITS-1:0] d;
      d = x - y;
      if (d[TIME_BITS-1]) begin
         d = ~d + TIME_BITS'(1);
      end
      return d;
   endfunction

endpackage

### src/tbolm_ram.sv
// ---------------------------------------------------------------------------
// tbolm_ram
// generic single write, single read ram with registered read data
// ---------------------------------------------------------------------------
module tbolm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tbolm_ctrl.sv
// ---------------------------------------------------------------------------
// tbolm_ctrl
// sequencer: queue clear, push and pop, difference and sum steps, multiply,
// bit-serial divide and result hand-off
// ---------------------------------------------------------------------------
module tbolm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  tbolm_pkg::dp_status_type status,
   output tbolm_pkg::dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_CHECK     = 12'b0000_0000_0010,
      ST_RD0       = 12'b0000_0000_0100,
      ST_RD1       = 12'b0000_0000_1000,
      ST_RD2       = 12'b0000_0001_0000,
      ST_DIFF      = 12'b0000_0010_0000,
      ST_SUM       = 12'b0000_0100_0000,
      ST_MUL       = 12'b0000_1000_0000,
      ST_DIV       = 12'b0001_0000_0000,
      ST_EMIT_DROP = 12'b0010_0000_0000,
      ST_EMIT_ZERO = 12'b0100_0000_0000,
      ST_EMIT_CALC = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               priority if (status.item_clear) begin
                  cmd.clear = 1'b1;
               end else if (status.item_full) begin
                  state_in = ST_EMIT_DROP;
               end else begin
                  cmd.push = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            state_in = status.pair_ready ? ST_RD0 : ST_IDLE;
         end
         ST_RD0: begin
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd_next = 1'b1;
            cmd.cap_in  = 1'b1;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            cmd.pop  = 1'b1;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = ST_SUM;
         end
         ST_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            if (status.den_zero) begin
               state_in = ST_EMIT_ZERO;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT_CALC;
            end
         end
         ST_EMIT_DROP: begin
            cmd.emit_kind = tbolm_pkg::EMIT_DROP;
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_ZERO: begin
            cmd.emit_kind = tbolm_pkg::EMIT_ZERO;
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_CALC: begin
            cmd.emit_kind = tbolm_pkg::EMIT_CALC;
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/tbolm_dp.sv
// ---------------------------------------------------------------------------
// tbolm_dp
// timestamp queues, distance register, difference and sum stages,
// multiplier, restoring divider and result register
// ---------------------------------------------------------------------------
`include "two_beam_object_length_meter_top_assert.svh"

module tbolm_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tbolm_pkg::dp_cmd_type                cmd,
   output tbolm_pkg::dp_status_type             status,
   input  tbolm_pkg::req_payload_type           req_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbolm_pkg::DIST_W-1:0]         csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tbolm_pkg::rsp_payload_type           rsp_payload
);

   logic [tbolm_pkg::DIST_W-1:0]    dist_ff,    dist_in;
   logic [tbolm_pkg::IDX_W-1:0]     head_a_ff,  head_a_in;
   logic [tbolm_pkg::IDX_W-1:0]     head_b_ff,  head_b_in;
   logic [tbolm_pkg::FILL_W-1:0]    fill_a_ff,  fill_a_in;
   logic [tbolm_pkg::FILL_W-1:0]    fill_b_ff,  fill_b_in;
   logic [tbolm_pkg::TIME_BITS-1:0] ain_ff,     ain_in;
   logic [tbolm_pkg::TIME_BITS-1:0] aout_ff,    aout_in;
   logic [tbolm_pkg::TIME_BITS-1:0] bin_ff,     bin_in;
   logic [tbolm_pkg::TIME_BITS-1:0] bout_ff,    bout_in;
   logic [tbolm_pkg::TIME_BITS-1:0] dab_in_ff,  dab_in_in;
   logic [tbolm_pkg::TIME_BITS-1:0] dab_out_ff, dab_out_in;
   logic [tbolm_pkg::TIME_BITS-1:0] da_ff,      da_in;
   logic [tbolm_pkg::TIME_BITS-1:0] db_ff,      db_in;
   logic [tbolm_pkg::REM_W-1:0]     num_ff,     num_in;
   logic [tbolm_pkg::REM_W-1:0]     den_ff,     den_in;
   logic [tbolm_pkg::PROD_W-1:0]    prod_ff,    prod_in;
   logic [tbolm_pkg::REM_W-1:0]     rem_ff,     rem_in;
   logic [tbolm_pkg::LEN_W-1:0]     quo_ff,     quo_in;
   logic                            ovf_ff,     ovf_in;
   logic [tbolm_pkg::CNT_W-1:0]     cnt_ff,     cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   tbolm_pkg::rsp_payload_type      rsp_data_ff,  rsp_data_in;

   logic [tbolm_pkg::TIME_BITS-1:0] stamp;
   logic                            push_a;
   logic                            push_b;
   logic [tbolm_pkg::IDX_W-1:0]     wr_addr_a;
   logic [tbolm_pkg::IDX_W-1:0]     wr_addr_b;
   logic [tbolm_pkg::IDX_W-1:0]     rd_addr_a;
   logic [tbolm_pkg::IDX_W-1:0]     rd_addr_b;
   logic [tbolm_pkg::TIME_BITS-1:0] rd_data_a;
   logic [tbolm_pkg::TIME_BITS-1:0] rd_data_b;
   logic [tbolm_pkg::REM_W:0]       rem_shift;
   logic [tbolm_pkg::REM_W:0]       den_ext;
   logic                            quo_bit;

   // queue write and read addressing
   assign stamp     = req_payload.edge_time[tbolm_pkg::TIME_BITS-1:0];
   assign push_a    = cmd.push && (req_payload.sensor_select == tbolm_pkg::SENSOR_A);
   assign push_b    = cmd.push && (req_payload.sensor_select == tbolm_pkg::SENSOR_B);
   assign wr_addr_a = tbolm_pkg::idx_add(head_a_ff, fill_a_ff);
   assign wr_addr_b = tbolm_pkg::idx_add(head_b_ff, fill_b_ff);
   assign rd_addr_a = cmd.rd_next ? tbolm_pkg::idx_add(head_a_ff, tbolm_pkg::FILL_ONE)
                                  : head_a_ff;
   assign rd_addr_b = cmd.rd_next ? tbolm_pkg::idx_add(head_b_ff, tbolm_pkg::FILL_ONE)
                                  : head_b_ff;

   tbolm_ram #(
      .WIDTH (tbolm_pkg::TIME_BITS),
      .DEPTH (tbolm_pkg::QUEUE_DEPTH)
   ) u_queue_a (
      .clock   (clock),
      .wr_en   (push_a),
      .wr_addr (wr_addr_a),
      .wr_data (stamp),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   tbolm_ram #(
      .WIDTH (tbolm_pkg::TIME_BITS),
      .DEPTH (tbolm_pkg::QUEUE_DEPTH)
   ) u_queue_b (
      .clock   (clock),
      .wr_en   (push_b),
      .wr_addr (wr_addr_b),
      .wr_data (stamp),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // one restoring divide step
   assign rem_shift = {rem_ff, prod_ff[tbolm_pkg::PROD_W-1]};
   assign den_ext   = {1'b0, den_ff};
   assign quo_bit   = (rem_shift >= den_ext);

   always_comb begin
      dist_in      = dist_ff;
      head_a_in    = head_a_ff;
      head_b_in    = head_b_ff;
      fill_a_in    = fill_a_ff;
      fill_b_in    = fill_b_ff;
      ain_in       = ain_ff;
      aout_in      = aout_ff;
      bin_in       = bin_ff;
      bout_in      = bout_ff;
      dab_in_in    = dab_in_ff;
      dab_out_in   = dab_out_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         dist_in = csr_data;
      end

      if (cmd.clear) begin
         head_a_in = '0;
         head_b_in = '0;
         fill_a_in = '0;
         fill_b_in = '0;
      end

      if (push_a) begin
         fill_a_in = fill_a_ff + tbolm_pkg::FILL_ONE;
      end
      if (push_b) begin
         fill_b_in = fill_b_ff + tbolm_pkg::FILL_ONE;
      end

      if (cmd.cap_in) begin
         ain_in = rd_data_a;
         bin_in = rd_data_b;
      end

      if (cmd.pop) begin
         aout_in   = rd_data_a;
         bout_in   = rd_data_b;
         head_a_in = tbolm_pkg::idx_add(head_a_ff, tbolm_pkg::FILL_TWO);
         head_b_in = tbolm_pkg::idx_add(head_b_ff, tbolm_pkg::FILL_TWO);
         fill_a_in = fill_a_ff - tbolm_pkg::FILL_TWO;
         fill_b_in = fill_b_ff - tbolm_pkg::FILL_TWO;
      end

      if (cmd.calc_diff) begin
         dab_in_in  = tbolm_pkg::abs_diff(ain_ff, bin_ff);
         dab_out_in = tbolm_pkg::abs_diff(aout_ff, bout_ff);
         da_in      = aout_ff - ain_ff;
         db_in      = bout_ff - bin_ff;
      end

      if (cmd.calc_sum) begin
         num_in = {1'b0, da_ff} + {1'b0, db_ff};
         den_in = {1'b0, dab_in_ff} + {1'b0, dab_out_ff};
      end

      if (cmd.mul) begin
         prod_in = tbolm_pkg::PROD_W'(num_ff) * tbolm_pkg::PROD_W'(dist_ff);
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
      end

      if (cmd.div_step) begin
         prod_in = {prod_ff[tbolm_pkg::PROD_W-2:0], 1'b0};
         rem_in  = quo_bit ? tbolm_pkg::REM_W'(rem_shift - den_ext)
                           : rem_shift[tbolm_pkg::REM_W-1:0];
         quo_in  = {quo_ff[tbolm_pkg::LEN_W-2:0], quo_bit};
         ovf_in  = ovf_ff | quo_ff[tbolm_pkg::LEN_W-1];
         cnt_in  = cnt_ff + tbolm_pkg::CNT_W'(1);
      end

      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.emit_kind)
            tbolm_pkg::EMIT_DROP: begin
               rsp_data_in.status        = tbolm_pkg::STATUS_DROPPED;
               rsp_data_in.object_length = '0;
            end
            tbolm_pkg::EMIT_ZERO: begin
               rsp_data_in.status        = tbolm_pkg::STATUS_ZERO_DELAY;
               rsp_data_in.object_length = '0;
            end
            tbolm_pkg::EMIT_CALC: begin
               if (ovf_ff) begin
                  rsp_data_in.status        = tbolm_pkg::STATUS_SATURATED;
                  rsp_data_in.object_length = '1;
               end else begin
                  rsp_data_in.status        = tbolm_pkg::STATUS_OK;
                  rsp_data_in.object_length = quo_ff;
               end
            end
            default: begin
               rsp_data_in.status        = tbolm_pkg::STATUS_DROPPED;
               rsp_data_in.object_length = '0;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff      <= tbolm_pkg::DIST_RESET;
         head_a_ff    <= '0;
         head_b_ff    <= '0;
         fill_a_ff    <= '0;
         fill_b_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dist_ff      <= dist_in;
         head_a_ff    <= head_a_in;
         head_b_ff    <= head_b_in;
         fill_a_ff    <= fill_a_in;
         fill_b_ff    <= fill_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ain_ff      <= ain_in;
      aout_ff     <= aout_in;
      bin_ff      <= bin_in;
      bout_ff     <= bout_in;
      dab_in_ff   <= dab_in_in;
      dab_out_ff  <= dab_out_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      ovf_ff      <= ovf_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // status towards the sequencer
   assign status.item_clear = (req_payload.command == tbolm_pkg::CMD_CLEAR);
   assign status.item_full  = (req_payload.sensor_select == tbolm_pkg::SENSOR_A)
                              ? (fill_a_ff == tbolm_pkg::FILL_FULL)
                              : (fill_b_ff == tbolm_pkg::FILL_FULL);
   assign status.pair_ready = (fill_a_ff >= tbolm_pkg::FILL_TWO) &&
                              (fill_b_ff >= tbolm_pkg::FILL_TWO);
   assign status.den_zero   = (den_ff == '0);
   assign status.div_last   = (cnt_ff == tbolm_pkg::DIV_LAST);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `TBOLM_ASSERT_ALWAYS(a_fill_bound, clock, reset,
      (fill_a_ff <= tbolm_pkg::FILL_FULL) && (fill_b_ff <= tbolm_pkg::FILL_FULL))
   `TBOLM_ASSERT_IMPLY(a_pop_has_pairs, clock, reset, cmd.pop,
      (fill_a_ff >= tbolm_pkg::FILL_TWO) && (fill_b_ff >= tbolm_pkg::FILL_TWO))
   `TBOLM_ASSERT_IMPLY(a_load_no_overwrite, clock, reset, cmd.load,
      !rsp_valid_ff || rsp_ready)
   `TBOLM_ASSERT_IMPLY(a_rem_below_den, clock, reset, cmd.div_step, rem_ff < den_ff)

endmodule

### src/two_beam_object_length_meter_top.sv
// ---------------------------------------------------------------------------
// two_beam_object_length_meter_top
// length from two barrier timestamp queues: distance times summed
// occupancy over summed barrier delays, with drop, zero and overflow status
//
//   channel  direction  payload                              handshake
//   req      in         command, sensor_select, edge_time    req_valid/ready
//   rsp      out        status, object_length                rsp_valid/ready
//   csr      in         barrier spacing                      csr_valid/ready
//
// clear acts in the idle state; a queued timestamp passes a check state, a drop its emit state
// a measurement passes read, difference, sum and multiply steps and the one bit a cycle divider
// synchronous reset, queues empty at once, no memory clearing pass
// a new beat is taken while a result waits in the output register
// a further result then waits in the sequencer until that register frees
// ---------------------------------------------------------------------------
module two_beam_object_length_meter_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tbolm_pkg::req_payload_type   req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tbolm_pkg::rsp_payload_type   rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tbolm_pkg::DIST_W-1:0] csr_data
);

   tbolm_pkg::dp_cmd_type    cmd;
   tbolm_pkg::dp_status_type status;

   tbolm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbolm_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
